>>> src/iqr_pkg.sv
// Shared types and constants for the IQR outlier bounds block.
package iqr_pkg;

    localparam int NBIN_DEF     = 1024;
    localparam int SAMPLE_W     = 32;
    localparam int THRESH_W     = 12;
    localparam int BOUND_W      = 48;
    localparam int KEPT_W       = 11;
    localparam int STATUS_W     = 2;
    localparam int SPREAD_W     = SAMPLE_W + THRESH_W;
    localparam int OUT_DATA_W   = 112;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd384;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_DROPPED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_DRAIN,
        S_MUL,
        S_FIN
    } state_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic ins_en;    // insert the broadcast sample in order
        logic shift_en;  // move every entry one place toward the head
    } cell_ctrl_t;

endpackage

>>> src/iqr_cell.sv
// One sorter cell: holds one sample, inserts in order or shifts toward the head.
module iqr_cell (
    input  logic                              aclk,
    input  iqr_pkg::cell_ctrl_t               ctrl,
    input  logic signed [iqr_pkg::SAMPLE_W-1:0] sample,
    input  logic                              occupied,
    input  logic                              left_ins,
    input  logic signed [iqr_pkg::SAMPLE_W-1:0] left_val,
    input  logic signed [iqr_pkg::SAMPLE_W-1:0] right_val,
    output logic                              ins,
    output logic signed [iqr_pkg::SAMPLE_W-1:0] val
);

    logic signed [iqr_pkg::SAMPLE_W-1:0] val_reg;
    logic signed [iqr_pkg::SAMPLE_W-1:0] val_next;

    // Entry stays put only if it is held and not greater than the new sample.
    assign ins = !(occupied && (val_reg <= sample));
    assign val = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ctrl.ins_en && ins) begin
            val_next = left_ins ? left_val : sample;
        end else if (ctrl.shift_en) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

>>> src/iqr_row.sv
// Row of sorter cells forming the ordered sample store.
module iqr_row #(
    parameter int NBIN = iqr_pkg::NBIN_DEF,
    parameter int CW   = $clog2(NBIN + 1)
) (
    input  logic                                aclk,
    input  iqr_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [iqr_pkg::SAMPLE_W-1:0] sample,
    input  logic [CW-1:0]                       held_count,
    output logic signed [iqr_pkg::SAMPLE_W-1:0] head
);

    logic [NBIN-1:0]                     ins;
    logic [NBIN-1:0]                     occ;
    logic signed [iqr_pkg::SAMPLE_W-1:0] vals [NBIN];

    assign head = vals[0];

    for (genvar i = 0; i < NBIN; i++) begin : g_cell
        logic                                l_ins;
        logic signed [iqr_pkg::SAMPLE_W-1:0] l_val;
        logic signed [iqr_pkg::SAMPLE_W-1:0] r_val;

        assign occ[i] = (CW'(i) < held_count);

        if (i == 0) begin : g_first
            assign l_ins = 1'b0;
            assign l_val = sample;
        end else begin : g_mid
            assign l_ins = ins[i-1];
            assign l_val = vals[i-1];
        end

        if (i == NBIN - 1) begin : g_tail
            assign r_val = vals[i];
        end else begin : g_body
            assign r_val = vals[i+1];
        end

        iqr_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .sample    (sample),
            .occupied  (occ[i]),
            .left_ins  (l_ins),
            .left_val  (l_val),
            .right_val (r_val),
            .ins       (ins[i]),
            .val       (vals[i])
        );
    end

endmodule

>>> src/iqr_outlier_bounds.sv
// Top level: Tukey fence bounds from the interquartile range of a sample set.
// Throughput: one sample word per cycle within a set (insertion into the cell row).
// After the last word of a set, the row drains to the Q3 position, the spread is multiplied
//   and the final add registers the result once the output is free; an empty set goes straight to the final add.
// The input holds off (s_tready low) from the last word until the result is registered.
// Reset (aresetn low, synchronous): control state cleared, threshold back to 1.5;
//   cell contents are not reset, entries past the held count are never read.
module iqr_outlier_bounds #(
    parameter int NBIN = iqr_pkg::NBIN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // slave side
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // [31:0] sample
    input  logic                               s_tuser,  // keep
    input  logic                               s_tlast,  // last
    // master side
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [iqr_pkg::OUT_DATA_W-1:0]     m_tdata,  // [47:0] lower_bound, [95:48]
                                                         // upper_bound, [106:96] kept_count,
                                                         // [108:107] status, rest zero
    // threshold register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [iqr_pkg::THRESH_W-1:0]       cfg_data
);

    localparam int CW = $clog2(NBIN + 1);
    localparam int IW = $clog2(NBIN);
    localparam int SW = iqr_pkg::SAMPLE_W;
    localparam int BW = iqr_pkg::BOUND_W;

    iqr_pkg::state_t state_reg, state_next;

    logic [iqr_pkg::THRESH_W-1:0] thresh_reg;
    logic [CW-1:0]                held_reg, held_next;
    logic                         drop_reg, drop_next;
    logic [CW-1:0]                set_cnt_reg, set_cnt_next;
    logic                         set_drop_reg, set_drop_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic signed [SW-1:0]         q1_reg, q1_next;
    logic signed [SW-1:0]         q3_reg, q3_next;
    logic [iqr_pkg::SPREAD_W-1:0] spread_reg, spread_next;

    logic                         m_valid_reg, m_valid_next;
    logic signed [BW-1:0]         lo_reg, lo_next;
    logic signed [BW-1:0]         hi_reg, hi_next;
    logic [iqr_pkg::KEPT_W-1:0]   kept_reg, kept_next;
    iqr_pkg::status_t             stat_reg, stat_next;

    iqr_pkg::cell_ctrl_t          ctrl;
    logic signed [SW-1:0]         head;
    logic                         s_acc;
    logic                         room;
    logic [CW-1:0]                cnt_final;
    logic [IW-1:0]                i1, i3;
    logic [CW+1:0]                cnt_x3;
    logic [SW:0]                  iqr_wide;
    logic signed [BW-1:0]         q1_scaled, q3_scaled, spread_ext;

    assign s_tready  = (state_reg == iqr_pkg::S_LOAD);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign room      = (held_reg < CW'(NBIN));

    // Quartile positions within the set just closed.
    assign i1     = IW'(set_cnt_reg >> 2);
    assign cnt_x3 = {set_cnt_reg, 1'b0} + (CW+2)'(set_cnt_reg);
    assign i3     = IW'(cnt_x3 >> 2);

    // IQR is never negative since the store is sorted; 32 bits unsigned suffice.
    assign iqr_wide   = (SW+1)'(q3_reg) - (SW+1)'(q1_reg);
    assign q1_scaled  = {{(BW-SW-8){q1_reg[SW-1]}}, q1_reg, 8'd0};
    assign q3_scaled  = {{(BW-SW-8){q3_reg[SW-1]}}, q3_reg, 8'd0};
    assign spread_ext = BW'(spread_reg);

    iqr_row #(
        .NBIN (NBIN),
        .CW   (CW)
    ) u_row (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .sample     (s_tdata),
        .held_count (held_reg),
        .head       (head)
    );

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        drop_next     = drop_reg;
        set_cnt_next  = set_cnt_reg;
        set_drop_next = set_drop_reg;
        idx_next      = idx_reg;
        q1_next       = q1_reg;
        q3_next       = q3_reg;
        spread_next   = spread_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        kept_next     = kept_reg;
        stat_next     = stat_reg;
        ctrl          = '0;
        cnt_final     = held_reg;

        unique case (state_reg)
            iqr_pkg::S_LOAD: begin
                if (s_acc) begin
                    if (s_tuser && room) begin
                        ctrl.ins_en = 1'b1;
                        cnt_final   = held_reg + CW'(1);
                    end
                    held_next = cnt_final;
                    drop_next = drop_reg || (s_tuser && !room);
                    if (s_tlast) begin
                        set_cnt_next  = cnt_final;
                        set_drop_next = drop_next;
                        held_next     = '0;
                        drop_next     = 1'b0;
                        idx_next      = '0;
                        state_next    = (cnt_final == '0) ? iqr_pkg::S_FIN
                                                          : iqr_pkg::S_DRAIN;
                    end
                end
            end
            iqr_pkg::S_DRAIN: begin
                // Head cell holds the entry at idx_reg; row moves up each cycle.
                ctrl.shift_en = 1'b1;
                idx_next      = idx_reg + IW'(1);
                if (idx_reg == i1) begin
                    q1_next = head;
                end
                if (idx_reg == i3) begin
                    q3_next    = head;
                    state_next = iqr_pkg::S_MUL;
                end
            end
            iqr_pkg::S_MUL: begin
                spread_next = iqr_pkg::SPREAD_W'(thresh_reg) * iqr_pkg::SPREAD_W'(iqr_wide[SW-1:0]);
                state_next  = iqr_pkg::S_FIN;
            end
            iqr_pkg::S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    kept_next    = iqr_pkg::KEPT_W'(set_cnt_reg);
                    if (set_cnt_reg == '0) begin
                        lo_next   = '0;
                        hi_next   = '0;
                        stat_next = iqr_pkg::STAT_EMPTY;
                    end else begin
                        lo_next   = q1_scaled - spread_ext;
                        hi_next   = q3_scaled + spread_ext;
                        stat_next = set_drop_reg ? iqr_pkg::STAT_DROPPED : iqr_pkg::STAT_OK;
                    end
                    state_next = iqr_pkg::S_LOAD;
                end
            end
            default: state_next = iqr_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= iqr_pkg::S_LOAD;
            thresh_reg   <= iqr_pkg::THRESH_RESET;
            held_reg     <= '0;
            drop_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            drop_reg     <= drop_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        set_cnt_reg  <= set_cnt_next;
        set_drop_reg <= set_drop_next;
        idx_reg      <= idx_next;
        q1_reg       <= q1_next;
        q3_reg       <= q3_next;
        spread_reg   <= spread_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        kept_reg     <= kept_next;
        stat_reg     <= stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, stat_reg, kept_reg, hi_reg, lo_reg};

    // Held count never exceeds the row length.
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CW'(NBIN))
        else $error("held count beyond capacity");

    // A closing word empties the store for the next set.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> (held_reg == '0) && !drop_reg)
        else $error("store not emptied after last word");

    // Drain stops at Q3, never runs past it.
    a_drain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == iqr_pkg::S_DRAIN |-> idx_reg <= i3)
        else $error("drain ran past Q3 position");

    // Empty status only with zero kept count.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (stat_reg == iqr_pkg::STAT_EMPTY) |-> kept_reg == '0)
        else $error("empty status with nonzero count");

endmodule

>>> test/tb.sv
// Self-checking testbench for iqr_outlier_bounds: directed table, then random sets per threshold.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBIN        = iqr_pkg::NBIN_DEF;
    localparam int STALL_LIMIT = 4000;   // longest quiet stretch: full-store drain plus stalls
    localparam int TAIL_CYCLES = 40;     // watch for stray words once everything has arrived
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 70;     // small-set words per phase

    // One result word, fields in tdata order.
    typedef struct packed {
        logic [iqr_pkg::BOUND_W-1:0] lower;
        logic [iqr_pkg::BOUND_W-1:0] upper;
        logic [iqr_pkg::KEPT_W-1:0]  kept;
        iqr_pkg::status_t            status;
    } fence_t;

    // Directed row: word to send and, where obvious, the fence it must produce.
    typedef struct {
        logic [iqr_pkg::SAMPLE_W-1:0] sample;
        logic                         keep;
        logic                         last;
        bit                           typed;
        fence_t                       want;
    } stim_row_t;

    localparam fence_t NO_FENCE    = '{48'h0, 48'h0, 11'd0, iqr_pkg::STAT_OK};
    localparam fence_t EMPTY_FENCE = '{48'h0, 48'h0, 11'd0, iqr_pkg::STAT_EMPTY};
    localparam int     DIR_ROWS    = 18;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [iqr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [iqr_pkg::THRESH_W-1:0]   cfg_data  = '0;

    // Predictor state: sorted copy of the kept samples, drop flag, threshold.
    int                           held_sorted[$];
    bit                           drop_seen;
    logic [iqr_pkg::THRESH_W-1:0] threshold_now;

    fence_t              pending_fences[$];
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;
    int                  sender_idle_pct = 23;
    int                  sink_idle_pct   = 23;

    stim_row_t           dir_rows[DIR_ROWS];

    iqr_outlier_bounds dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predict the effect of one accepted sample word. fires is set on a last word,
    // with the fence it must produce; the set is then emptied.
    task automatic predict_word(input logic [31:0] sample, input logic keep,
                                input logic last, output bit fires, output fence_t fence);
        int     pos;
        int     n;
        longint q1;
        longint q3;
        longint spread;
        longint lo;
        longint hi;
        fires = 1'b0;
        fence = NO_FENCE;
        if (keep) begin
            if (held_sorted.size() < NBIN) begin
                pos = 0;
                while (pos < held_sorted.size() && held_sorted[pos] <= int'(sample))
                    pos++;
                held_sorted.insert(pos, int'(sample));
            end else begin
                drop_seen = 1'b1;
            end
        end
        if (last) begin
            fires = 1'b1;
            n = held_sorted.size();
            if (n == 0) begin
                fence = EMPTY_FENCE;
            end else begin
                // Q1 at n/4, Q3 at 3n/4; bounds carry 8 fraction bits
                q1 = held_sorted[n / 4];
                q3 = held_sorted[(3 * n) / 4];
                spread = longint'(threshold_now) * (q3 - q1);
                lo = q1 * 256 - spread;
                hi = q3 * 256 + spread;
                fence.lower  = lo[iqr_pkg::BOUND_W-1:0];
                fence.upper  = hi[iqr_pkg::BOUND_W-1:0];
                fence.kept   = n[iqr_pkg::KEPT_W-1:0];
                fence.status = drop_seen ? iqr_pkg::STAT_DROPPED : iqr_pkg::STAT_OK;
            end
            held_sorted.delete();
            drop_seen = 1'b0;
        end
    endtask

    // Offer one sample word, with random idle cycles ahead of it, and account for it
    // once accepted. A typed row overrides the predicted fence.
    task automatic send_word(input logic [31:0] sample, input logic keep, input logic last,
                             input bit typed, input fence_t typed_fence);
        bit     fires;
        fence_t fence;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= keep;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_word(sample, keep, last, fires, fence);
        if (fires)
            pending_fences.push_back(typed ? typed_fence : fence);
    endtask

    // Mostly a spread of shapes: full range, clustered small values (duplicates),
    // the two extremes, and moderate values of either sign.
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(16)) - 8);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'(-$signed({1'b0, $urandom_range(100000)}));
            default: return 32'($urandom_range(100000));
        endcase
    endfunction

    // One set of n words; the final word carries last.
    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_word(pick_sample(), ($urandom_range(99) < 80), (i == n - 1), 1'b0, NO_FENCE);
    endtask

    // Stop offering words and wait for every pending fence to come out.
    task automatic drain_fences();
        s_tvalid <= 1'b0;
        while (pending_fences.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [iqr_pkg::THRESH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        threshold_now = value;
    endtask

    // Result side: check each accepted word against the oldest pending fence,
    // then pick ready for the next cycle.
    always @(posedge aclk) begin : result_sink
        fence_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_fences.size() == 0) begin
                $error("result word with no set pending: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_fences.pop_front();
                if (m_tdata[47:0] !== want.lower) begin
                    $error("lower_bound: expected %h, got %h", want.lower, m_tdata[47:0]);
                    mismatch_count++;
                end
                if (m_tdata[95:48] !== want.upper) begin
                    $error("upper_bound: expected %h, got %h", want.upper, m_tdata[95:48]);
                    mismatch_count++;
                end
                if (m_tdata[106:96] !== want.kept) begin
                    $error("kept_count: expected %0d, got %0d", want.kept, m_tdata[106:96]);
                    mismatch_count++;
                end
                if (m_tdata[108:107] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[108:107]);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: any accepted word on any channel resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [iqr_pkg::THRESH_W-1:0] plan_thresh[PHASES];
        int                           sent;
        int                           n;

        // Directed rows. Typed fences: sets with nothing kept, and single-sample sets
        // at both extremes (IQR is zero, so both bounds are the sample times 256).
        dir_rows = '{
            '{32'h0000_0000, 1'b0, 1'b1, 1'b1, EMPTY_FENCE},   // lone last, nothing kept
            '{32'h0000_0005, 1'b0, 1'b0, 1'b0, NO_FENCE},
            '{32'hFFFF_FFF9, 1'b0, 1'b1, 1'b1, EMPTY_FENCE},   // words seen, none kept
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1,
              '{48'h007F_FFFF_FF00, 48'h007F_FFFF_FF00, 11'd1, iqr_pkg::STAT_OK}},
            '{32'h8000_0000, 1'b1, 1'b1, 1'b1,
              '{48'hFF80_0000_0000, 48'hFF80_0000_0000, 11'd1, iqr_pkg::STAT_OK}},
            // widest spread: Q1 at min, Q3 at max, last word not kept
            '{32'h8000_0000, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'h8000_0000, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'h0000_0000, 1'b0, 1'b1, 1'b0, NO_FENCE},
            // unsorted arrival with duplicates and a skipped word
            '{32'h0000_0003, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'h0000_0003, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_FENCE},
            '{32'h0000_0000, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'hFFFF_FFFB, 1'b1, 1'b1, 1'b0, NO_FENCE},
            // alternating bit patterns
            '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, NO_FENCE},
            '{32'h5555_5555, 1'b1, 1'b1, 1'b0, NO_FENCE}
        };

        threshold_now = iqr_pkg::THRESH_RESET;
        drop_seen     = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part runs on the reset threshold (1.5).
        foreach (dir_rows[i])
            send_word(dir_rows[i].sample, dir_rows[i].keep, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].want);

        // Threshold per phase: both extremes, smallest nonzero, random, back to 1.5.
        plan_thresh[0] = 12'h000;
        plan_thresh[1] = 12'hFFF;
        plan_thresh[2] = 12'h001;
        plan_thresh[3] = 12'($urandom_range(4095));
        plan_thresh[4] = iqr_pkg::THRESH_RESET;

        for (int p = 0; p < PHASES; p++) begin
            drain_fences();
            write_threshold(plan_thresh[p]);
            // phase 1 runs back to back on both sides
            sender_idle_pct = (p == 1) ? 0 : 23;
            sink_idle_pct   = (p == 1) ? 0 : 23;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_set(n);
                sent += n;
            end

            // Store overflow: fill every entry, then a few more kept words get dropped.
            if (p == 3) begin
                for (int i = 0; i < NBIN + 4; i++)
                    send_word(pick_sample(), 1'b1, (i == NBIN + 3), 1'b0, NO_FENCE);
            end
        end

        drain_fences();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> iqr_outlier_bounds.f
src/iqr_pkg.sv
src/iqr_cell.sv
src/iqr_row.sv
src/iqr_outlier_bounds.sv
test/tb.sv
